// ===== rtl/core/spike_rejecting_distance_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spike rejecting distance filter
// Shared property forms so that every check reports in the same way.
// ----------------------------------------------------------------------------
`ifndef SPIKE_REJECTING_DISTANCE_FILTER_UNIT_DEFINES_SVH
`define SPIKE_REJECTING_DISTANCE_FILTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRDF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srdf check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srdf check failed");

`endif

// ===== rtl/core/srdf_pkg.sv =====
// ----------------------------------------------------------------------------
// srdf_pkg
// Widths, depths, codes and shared types of the spike rejecting distance
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package srdf_pkg;

    localparam int DIST_W        = 13;
    localparam int AVERAGE_DEPTH = 8;
    localparam int STABLE_DEPTH  = 5;

    // A sum of AVERAGE_DEPTH distances stays below 2**DIST_W * AVERAGE_DEPTH.
    localparam int SUM_W      = DIST_W + $clog2(AVERAGE_DEPTH);
    localparam int CNT_W      = $clog2(AVERAGE_DEPTH + 1);
    localparam int STAB_CNT_W = $clog2(STABLE_DEPTH + 1);
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    localparam logic [CNT_W-1:0]      AVERAGE_FULL = CNT_W'(AVERAGE_DEPTH);
    localparam logic [STAB_CNT_W-1:0] STABLE_FULL  = STAB_CNT_W'(STABLE_DEPTH);
    localparam logic [DIV_CNT_W-1:0]  DIV_STEPS    = DIV_CNT_W'(SUM_W);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID_DISTANCE = 2'd1;

    localparam logic [DIST_W-1:0] SPIKE_THRESHOLD_RESET    = 13'd320;
    localparam logic [DIST_W-1:0] MAX_VALID_DISTANCE_RESET = 13'd6400;

    typedef enum logic [1:0] {
        STATUS_AVERAGED = 2'd0,
        STATUS_SPIKE    = 2'd1,
        STATUS_STABLE   = 2'd2,
        STATUS_INVALID  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPREAD,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic shift;
        logic fill;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/spike_rejecting_distance_filter_unit.sv =====
// Flow: an invalid sample goes from its beat straight to the output state; a rejected
// or stable spike first rotates the stability ring to find its spread, and an averaged
// sample rotates the average ring to sum it and then runs the serial divider before
// the output state. A new sample is accepted only in the idle state, in the cycle after
// the previous result enters the output register, so one sample is in flight at a time.
// Reset (synchronous, active low) clears the rings, the stability count and the held distance.
// ----------------------------------------------------------------------------
// spike_rejecting_distance_filter_unit
// Spike rejecting moving average filter for ultrasonic distance samples,
// built from two rings of shifting cells and a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_rejecting_distance_filter_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: [12:0] sample_distance, [15:13] zero
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,
    // m_tdata: [12:0] filtered_distance, [15:13] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [15:0]                   m_tdata,
    // m_tuser: [1:0] status
    output logic      [1:0]                    m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [srdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srdf_pkg::DIST_W-1:0]    cfg_data
);
    import srdf_pkg::*;

    state_t state_reg, state_next;

    logic [DIST_W-1:0]     thr_reg, max_reg;
    logic [DIST_W-1:0]     held_reg;
    logic [DIST_W-1:0]     samp_reg;
    logic [STAB_CNT_W-1:0] scnt_reg;
    logic [STAB_CNT_W-1:0] stab_scan_reg;
    logic [CNT_W-1:0]      avg_scan_reg;
    logic [DIST_W-1:0]     lo_reg, hi_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      num_reg;
    logic [DIST_W-1:0]     res_reg;
    status_t               status_reg;
    logic                  out_valid_reg;
    logic [DIST_W-1:0]     out_data_reg;
    status_t               out_status_reg;

    logic [DIST_W-1:0] s_in;
    logic [DIST_W-1:0] diff;
    logic              accept;
    logic              in_ok;
    logic              is_spike;
    logic              spread_ok;
    logic              stab_done;
    logic              avg_done;
    logic              out_load;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quo;

    cell_ctrl_t        stab_ctrl, avg_ctrl;
    logic [DIST_W-1:0] stab_head, avg_head;
    logic [DIST_W-1:0] stab_val [STABLE_DEPTH];
    logic [DIST_W-1:0] avg_val  [AVERAGE_DEPTH];
    logic [DIST_W-1:0] stab_tail, avg_tail;

    assign s_in      = s_tdata[DIST_W-1:0];
    assign accept    = s_tvalid && s_tready;
    assign in_ok     = (s_in != '0) && (s_in < max_reg);
    assign diff      = (s_in > held_reg) ? (s_in - held_reg) : (held_reg - s_in);
    assign is_spike  = (held_reg != '0) && (diff > thr_reg);
    assign stab_done = stab_scan_reg == STABLE_FULL;
    assign avg_done  = avg_scan_reg == AVERAGE_FULL;
    assign spread_ok = (scnt_reg == STABLE_FULL) && ((hi_reg - lo_reg) <= thr_reg);
    assign stab_tail = stab_val[STABLE_DEPTH-1];
    assign avg_tail  = avg_val[AVERAGE_DEPTH-1];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!in_ok) begin
                        state_next = ST_OUT;
                    end else if (is_spike) begin
                        state_next = ST_SPREAD;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SPREAD: begin
                if (stab_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_SUM: begin
                if (avg_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready        = 1'b0;
        stab_ctrl.shift = 1'b0;
        stab_ctrl.fill  = 1'b0;
        avg_ctrl.shift  = 1'b0;
        avg_ctrl.fill   = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                stab_ctrl.shift = s_tvalid && in_ok;
                avg_ctrl.shift  = s_tvalid && in_ok && !is_spike;
            end
            ST_SPREAD: begin
                stab_ctrl.shift = !stab_done;
                avg_ctrl.fill   = stab_done && spread_ok;
            end
            ST_SUM: begin
                avg_ctrl.shift = !avg_done;
                div_start      = avg_done;
            end
            ST_DIV: begin
            end
            ST_OUT: begin
                out_load = !out_valid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    // In the idle state a shift pushes the new sample; otherwise the ring rotates.
    assign stab_head = (state_reg == ST_IDLE) ? s_in : stab_tail;
    assign avg_head  = (state_reg == ST_IDLE) ? s_in : avg_tail;

    for (genvar i = 0; i < STABLE_DEPTH; i++) begin : g_stab
        srdf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (stab_ctrl),
            .left_in   ((i == 0) ? stab_head : stab_val[(i == 0) ? 0 : i - 1]),
            .fill_in   (samp_reg),
            .value_out (stab_val[i])
        );
    end

    for (genvar i = 0; i < AVERAGE_DEPTH; i++) begin : g_avg
        srdf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (avg_ctrl),
            .left_in   ((i == 0) ? avg_head : avg_val[(i == 0) ? 0 : i - 1]),
            .fill_in   (samp_reg),
            .value_out (avg_val[i])
        );
    end

    srdf_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (num_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            thr_reg       <= SPIKE_THRESHOLD_RESET;
            max_reg       <= MAX_VALID_DISTANCE_RESET;
            held_reg      <= '0;
            scnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SPIKE_THRESHOLD:    thr_reg <= cfg_data;
                    REG_MAX_VALID_DISTANCE: max_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept && in_ok) begin
                // A small change from a held distance restarts the stability run.
                if ((held_reg != '0) && !is_spike) begin
                    scnt_reg <= '0;
                end else if (scnt_reg < STABLE_FULL) begin
                    scnt_reg <= scnt_reg + STAB_CNT_W'(1);
                end
            end
            if (out_load) begin
                held_reg      <= res_reg;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            samp_reg      <= s_in;
            stab_scan_reg <= '0;
            avg_scan_reg  <= '0;
            sum_reg       <= '0;
            num_reg       <= '0;
            if (!in_ok) begin
                res_reg    <= held_reg;
                status_reg <= STATUS_INVALID;
            end
        end
        if ((state_reg == ST_SPREAD) && !stab_done) begin
            stab_scan_reg <= stab_scan_reg + STAB_CNT_W'(1);
            if (stab_scan_reg == '0) begin
                lo_reg <= stab_tail;
                hi_reg <= stab_tail;
            end else if (stab_tail != '0) begin
                if (stab_tail < lo_reg) begin
                    lo_reg <= stab_tail;
                end
                if (stab_tail > hi_reg) begin
                    hi_reg <= stab_tail;
                end
            end
        end
        if ((state_reg == ST_SPREAD) && stab_done) begin
            if (spread_ok) begin
                res_reg    <= samp_reg;
                status_reg <= STATUS_STABLE;
            end else begin
                res_reg    <= held_reg;
                status_reg <= STATUS_SPIKE;
            end
        end
        if ((state_reg == ST_SUM) && !avg_done) begin
            avg_scan_reg <= avg_scan_reg + CNT_W'(1);
            if (avg_tail != '0) begin
                sum_reg <= sum_reg + SUM_W'(avg_tail);
                num_reg <= num_reg + CNT_W'(1);
            end
        end
        if ((state_reg == ST_DIV) && div_done) begin
            res_reg    <= div_quo[DIST_W-1:0];
            status_reg <= STATUS_AVERAGED;
        end
        if (out_load) begin
            out_data_reg   <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(16 - DIST_W){1'b0}}, out_data_reg};
    assign m_tuser   = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/srdf_cell.sv =====
// ----------------------------------------------------------------------------
// srdf_cell
// One ring entry: takes its left neighbour's value on a shift, or the fill
// value when the whole ring is loaded at once.
// ----------------------------------------------------------------------------
`default_nettype none

module srdf_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire srdf_pkg::cell_ctrl_t       ctrl,
    input  wire logic [srdf_pkg::DIST_W-1:0] left_in,
    input  wire logic [srdf_pkg::DIST_W-1:0] fill_in,
    output logic      [srdf_pkg::DIST_W-1:0] value_out
);
    import srdf_pkg::*;

    logic [DIST_W-1:0] value_reg;
    logic [DIST_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctrl.fill) begin
            value_next = fill_in;
        end else if (ctrl.shift) begin
            value_next = left_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value_out = value_reg;

endmodule

`default_nettype wire

// ===== rtl/core/srdf_divider.sv =====
// ----------------------------------------------------------------------------
// srdf_divider
// Restoring divider, one quotient bit per cycle, for the ring mean.
// ----------------------------------------------------------------------------
`default_nettype none

module srdf_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [srdf_pkg::SUM_W-1:0] dividend,
    input  wire logic [srdf_pkg::CNT_W-1:0] divisor,
    output logic                            done,
    output logic      [srdf_pkg::SUM_W-1:0] quotient
);
    import srdf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     div_reg, div_next;

    logic [CNT_W:0] shifted;
    logic [CNT_W:0] trial;
    logic           ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        trial   = shifted - {1'b0, div_reg};
        ge      = shifted >= {1'b0, div_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_STEPS;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so it fits CNT_W bits.
            quo_next = {quo_reg[SUM_W-2:0], ge};
            rem_next = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/srdf_checker.sv =====
// ----------------------------------------------------------------------------
// srdf_port_checks
// Port level checks of the distance filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spike_rejecting_distance_filter_unit_defines.svh"

module srdf_port_checks (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [15:0]                   m_tdata,
    input  wire logic [1:0]                    m_tuser
);
    import srdf_pkg::*;

    logic [DIST_W-1:0] last_out_reg;
    logic [1:0]        pend_reg, pend_next;
    logic              in_beat, out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg + {1'b0, in_beat} - {1'b0, out_beat};
    end

    // Tracks the last delivered distance, which is the filter's held value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_out_reg <= '0;
            pend_reg     <= '0;
        end else begin
            pend_reg <= pend_next;
            if (out_beat) begin
                last_out_reg <= m_tdata[DIST_W-1:0];
            end
        end
    end

    `SRDF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `SRDF_ASSERT_NOW(a_repeat_held, aclk, aresetn, m_tvalid && (m_tuser == STATUS_SPIKE || m_tuser == STATUS_INVALID), m_tdata[DIST_W-1:0] == last_out_reg)
    `SRDF_ASSERT_NOW(a_nonzero_mean, aclk, aresetn, m_tvalid && (m_tuser == STATUS_AVERAGED || m_tuser == STATUS_STABLE), m_tdata[DIST_W-1:0] != '0)
    `SRDF_ASSERT_NOW(a_no_invented, aclk, aresetn, m_tvalid, pend_reg != 2'd0)
    `SRDF_ASSERT_NOW(a_one_waiting, aclk, aresetn, in_beat, pend_reg <= 2'd1)

endmodule

bind spike_rejecting_distance_filter_unit srdf_port_checks u_srdf_port_checks (.*);

`default_nettype wire

// ===== sim/srdf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srdf_checker
// Watches the sample, result and register channels of the distance filter.
// It keeps its own copy of the filter state, predicts the distance and status
// for every accepted sample, and compares them with the result beats in order.
// ----------------------------------------------------------------------------

module srdf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [15:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,
    input  logic [1:0]                     m_tuser,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [srdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srdf_pkg::DIST_W-1:0]    cfg_data,
    output int unsigned                    mismatch_count,
    output int unsigned                    outputs_due
);
    import srdf_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        status_t           status;
    } filter_out_t;

    filter_out_t       pending_outputs[$];

    logic [DIST_W-1:0] threshold_reg;
    logic [DIST_W-1:0] max_distance_reg;
    logic [DIST_W-1:0] held;
    logic [DIST_W-1:0] avg_ring[AVERAGE_DEPTH];
    logic [DIST_W-1:0] stab_ring[STABLE_DEPTH];
    int                avg_pos;
    int                stab_pos;
    int                stab_fill;

    initial begin
        mismatch_count = 0;
        outputs_due    = 0;
    end

    function automatic filter_out_t filter_sample(input logic [DIST_W-1:0] s);
        filter_out_t r;
        int          diff;
        int          lo;
        int          hi;
        int          sum;
        int          n;
        int          i;
        bit          averaged;
        if (s == 0 || s >= max_distance_reg) begin
            r.distance = held;
            r.status   = STATUS_INVALID;
        end else begin
            averaged = 1'b1;
            stab_ring[stab_pos] = s;
            stab_pos = (stab_pos + 1) % STABLE_DEPTH;
            if (stab_fill < STABLE_DEPTH)
                stab_fill++;
            r.distance = '0;
            r.status   = STATUS_AVERAGED;

            // With nothing held yet there is no spike test at all.
            if (held != 0) begin
                diff = (s > held) ? int'(s) - int'(held) : int'(held) - int'(s);
                if (diff > int'(threshold_reg)) begin
                    averaged = 1'b0;
                    lo = int'(stab_ring[0]);
                    hi = lo;
                    for (i = 1; i < STABLE_DEPTH; i++) begin
                        if (stab_ring[i] != 0) begin
                            if (int'(stab_ring[i]) < lo) lo = int'(stab_ring[i]);
                            if (int'(stab_ring[i]) > hi) hi = int'(stab_ring[i]);
                        end
                    end
                    if (stab_fill >= STABLE_DEPTH && hi - lo <= int'(threshold_reg)) begin
                        // A settled new level: restart the average from it.
                        for (i = 0; i < AVERAGE_DEPTH; i++)
                            avg_ring[i] = s;
                        avg_pos    = 0;
                        r.distance = s;
                        r.status   = STATUS_STABLE;
                    end else begin
                        r.distance = held;
                        r.status   = STATUS_SPIKE;
                    end
                end else begin
                    stab_fill = 0;
                end
            end

            if (averaged) begin
                avg_ring[avg_pos] = s;
                avg_pos = (avg_pos + 1) % AVERAGE_DEPTH;
                sum = 0;
                n   = 0;
                for (i = 0; i < AVERAGE_DEPTH; i++) begin
                    if (avg_ring[i] != 0) begin
                        sum += int'(avg_ring[i]);
                        n++;
                    end
                end
                r.distance = (n == 0) ? held : DIST_W'(sum / n);
                r.status   = STATUS_AVERAGED;
            end
        end
        held = r.distance;
        return r;
    endfunction

    always @(posedge aclk) begin
        filter_out_t exp_out;
        if (!aresetn) begin
            threshold_reg    = SPIKE_THRESHOLD_RESET;
            max_distance_reg = MAX_VALID_DISTANCE_RESET;
            held             = '0;
            foreach (avg_ring[i])
                avg_ring[i] = '0;
            foreach (stab_ring[i])
                stab_ring[i] = '0;
            avg_pos   = 0;
            stab_pos  = 0;
            stab_fill = 0;
            pending_outputs.delete();
        end else begin
            // Results are checked before the sample of this edge is predicted,
            // since a result can never belong to a sample taken in the same beat.
            if (m_tvalid && m_tready) begin
                if (pending_outputs.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat with none expected: distance %0d status %0d",
                             $time, m_tdata[DIST_W-1:0], m_tuser);
                end else begin
                    exp_out = pending_outputs.pop_front();
                    if (m_tdata[DIST_W-1:0] !== exp_out.distance) begin
                        mismatch_count++;
                        $display("%0t: distance expected %0d, actual %0d",
                                 $time, exp_out.distance, m_tdata[DIST_W-1:0]);
                    end
                    if (m_tuser !== exp_out.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, exp_out.status, m_tuser);
                    end
                    if (m_tdata[15:DIST_W] !== '0) begin
                        mismatch_count++;
                        $display("%0t: tdata padding expected 0, actual %0d",
                                 $time, m_tdata[15:DIST_W]);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SPIKE_THRESHOLD:    threshold_reg    = cfg_data;
                    REG_MAX_VALID_DISTANCE: max_distance_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_outputs.push_back(filter_sample(s_tdata[DIST_W-1:0]));
        end
        outputs_due <= pending_outputs.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the spike rejecting distance filter with a short directed sequence
// and then phases of random samples under several thresholds, maximum
// distances and handshake idling patterns. The checker predicts every result.
// ----------------------------------------------------------------------------

module testbench;

    import srdf_pkg::*;

    localparam int PHASES         = 8;
    localparam int HOLD_OFF_BEATS = 300;
    localparam int NEAR_SPAN_MAX  = 400;

    // Percentage of cycles in which the sender idles and the receiver stalls.
    localparam int IDLE_PCT[PHASES]  = '{0, 76, 0, 16, 0, 76, 0, 16};
    localparam int STALL_PCT[PHASES] = '{0, 0, 76, 16, 0, 0, 76, 16};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIST_W-1:0]    cfg_data;

    int unsigned          mismatch_count;
    int unsigned          outputs_due;

    int                   idle_pct;
    int                   stall_pct;
    int                   cur_threshold;
    int                   cur_max_distance;
    logic                 hold_active;
    event                 hold_start_ev;

    spike_rejecting_distance_filter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srdf_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outputs_due    (outputs_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Long receiver hold-off, so that the filter fills up and stalls its input.
    initial begin
        hold_active = 1'b0;
        forever begin
            @(hold_start_ev);
            hold_active = 1'b1;
            repeat (HOLD_OFF_BEATS) @(negedge aclk);
            hold_active = 1'b0;
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = !hold_active && (int'($urandom_range(0, 99)) >= stall_pct);
        end
    end

    // Clamps a wanted distance into the currently valid range where there is one.
    function automatic logic [DIST_W-1:0] fit_distance(input int v);
        int lowest;
        int highest;
        lowest  = (cur_max_distance >= 2) ? 1 : 0;
        highest = (cur_max_distance >= 2) ? cur_max_distance - 1 : 8191;
        if (v < lowest)
            v = lowest;
        if (v > highest)
            v = highest;
        return DIST_W'(v);
    endfunction

    // Entered and left at a falling edge.
    task automatic send_sample(input logic [DIST_W-1:0] distance);
        s_tvalid = 1'b0;
        while (int'($urandom_range(0, 99)) < idle_pct)
            @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, distance};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = DIST_W'(value);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == REG_SPIKE_THRESHOLD)
            cur_threshold = value;
        else
            cur_max_distance = value;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outputs_due != 0)
            @(negedge aclk);
    endtask

    initial begin
        int phase;
        int batch;
        int sent;
        int kind;
        int level;
        int target;
        int span;
        int run_len;
        logic [DIST_W-1:0] sample;

        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_SPIKE_THRESHOLD;
        cfg_data         = '0;
        idle_pct         = 0;
        stall_pct        = 0;
        cur_threshold    = int'(SPIKE_THRESHOLD_RESET);
        cur_max_distance = int'(MAX_VALID_DISTANCE_RESET);
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: invalid with nothing held, first average, small
        // changes, a run of spikes that settles into a new level, and the
        // invalid limit on both sides of the maximum.
        send_sample(13'd0);
        send_sample(13'd1000);
        send_sample(13'd1100);
        send_sample(13'd1200);
        repeat (5) send_sample(13'd3000);
        send_sample(13'd3050);
        send_sample(13'd8191);
        send_sample(13'd6399);
        send_sample(13'd6400);
        wait_drained();

        // Zero threshold: any change is a spike, only a repeat averages.
        write_register(REG_SPIKE_THRESHOLD, 0);
        write_register(REG_MAX_VALID_DISTANCE, 8191);
        repeat (5) send_sample(13'd8190);
        send_sample(13'd8190);
        send_sample(13'd8189);
        send_sample(13'd8191);
        wait_drained();

        // A maximum of 1 leaves no valid sample at all.
        write_register(REG_MAX_VALID_DISTANCE, 1);
        send_sample(13'd1);
        send_sample(13'd0);
        send_sample(13'd8191);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            batch = 205;
            case (phase)
                0: begin
                    write_register(REG_SPIKE_THRESHOLD, int'(SPIKE_THRESHOLD_RESET));
                    write_register(REG_MAX_VALID_DISTANCE, int'(MAX_VALID_DISTANCE_RESET));
                end
                1: begin
                    write_register(REG_SPIKE_THRESHOLD, 8191);
                    write_register(REG_MAX_VALID_DISTANCE, 8191);
                end
                2: begin
                    write_register(REG_SPIKE_THRESHOLD, int'($urandom_range(16, 800)));
                    write_register(REG_MAX_VALID_DISTANCE, int'($urandom_range(2000, 8191)));
                end
                3: begin
                    write_register(REG_SPIKE_THRESHOLD, 0);
                    write_register(REG_MAX_VALID_DISTANCE, 8191);
                end
                4: begin
                    write_register(REG_SPIKE_THRESHOLD, int'($urandom_range(0, 8191)));
                    write_register(REG_MAX_VALID_DISTANCE, 1);
                    batch = 60;
                end
                5: begin
                    write_register(REG_SPIKE_THRESHOLD, int'($urandom_range(100, 400)));
                    write_register(REG_MAX_VALID_DISTANCE, int'(MAX_VALID_DISTANCE_RESET));
                end
                6: begin
                    write_register(REG_SPIKE_THRESHOLD, 1);
                    write_register(REG_MAX_VALID_DISTANCE, int'($urandom_range(1, 8191)));
                end
                default: begin
                    write_register(REG_SPIKE_THRESHOLD, int'($urandom_range(0, 8191)));
                    write_register(REG_MAX_VALID_DISTANCE, int'($urandom_range(100, 8191)));
                end
            endcase
            idle_pct  = IDLE_PCT[phase];
            stall_pct = STALL_PCT[phase];
            if (phase == 0)
                -> hold_start_ev;

            sent  = 0;
            level = int'(fit_distance(int'($urandom_range(1, 8191))));
            span  = (cur_threshold < NEAR_SPAN_MAX) ? cur_threshold : NEAR_SPAN_MAX;
            while (sent < batch) begin
                kind = int'($urandom_range(0, 99));
                if (kind < 60) begin
                    // Drift around the current level.
                    sample = fit_distance(level + int'($urandom_range(0, 2 * span)) - span);
                    send_sample(sample);
                    level = int'(sample);
                    sent++;
                end else if (kind < 75) begin
                    // A jump to a new level in a run that may be believed.
                    target = cur_threshold + 1 + int'($urandom_range(0, 1500));
                    target = $urandom_range(0, 1) ? level + target : level - target;
                    run_len = int'($urandom_range(4, 7));
                    repeat (run_len) begin
                        send_sample(fit_distance(target +
                                                 int'($urandom_range(0, cur_threshold / 2))));
                    end
                    level = int'(fit_distance(target));
                    sent += run_len;
                end else if (kind < 85) begin
                    send_sample(fit_distance(int'($urandom_range(1, 8191))));
                    sent++;
                end else if (kind < 93) begin
                    if ($urandom_range(0, 1))
                        send_sample(13'd0);
                    else
                        send_sample(DIST_W'($urandom_range(cur_max_distance, 8191)));
                    sent++;
                end else begin
                    send_sample(DIST_W'($urandom_range(0, 8191)));
                    sent++;
                end
            end
            wait_drained();
        end

        repeat (40) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
